>>> rtl/gsbd_pkg.sv
// ----------------------------------------------------------------------------
// gsbd_pkg
// Shared types and constants for the signed Golomb bit decoder: the payload
// structs of both channels, the status codes and the register indexes.
// ----------------------------------------------------------------------------
package gsbd_pkg;

  localparam int unsigned DIV_W     = 16;  // divisor register width
  localparam int unsigned RW_W      = 5;   // remainder width b, 0..16
  localparam int unsigned VALUE_W   = 29;
  localparam int unsigned LENGTH_W  = 13;
  localparam int unsigned NUM_W     = 30;  // unsigned code value, one bit above VALUE_W
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_MODE = 2'd1;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = 16'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic coded_bit;
    logic stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] decoded_value;
    logic [LENGTH_W-1:0]       code_length;
    status_t                   status;
  } out_item_t;

endpackage

>>> rtl/golomb_signed_bit_decoder_core.sv
// ----------------------------------------------------------------------------
// golomb_signed_bit_decoder_core
// Bit-serial Golomb decoder with truncated-binary remainder and signed
// output by zigzag mapping or a leading sign bit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one coded bit per word, with stream_end set on
//   the last bit that is available. The result channel gives one word per
//   finished code: the signed value, the number of bits the code took and a
//   status (ok, stream ended mid-code, quotient overflow).
//   Each bit is decoded in the cycle it is accepted; the result word appears
//   in the output register on the next cycle, and the block takes one bit
//   every cycle while no result word waits. The decoding state registers and
//   the output register are the only stages; each bit needs one add of the
//   divisor into the quotient base or one remainder compare.
//   While a result word waits for out_ready, the block takes a new bit only
//   in the cycle that word leaves, so nothing is lost or repeated.
//   Reset sets the divisor to 4 and zigzag mode and clears any code in
//   progress. A register write recomputes the remainder width and cutoff and
//   abandons the code in progress; write only while the block is idle. A
//   write to an index with no register behind it changes nothing.
// ----------------------------------------------------------------------------
module golomb_signed_bit_decoder_core
  import gsbd_pkg::*;
#(
  parameter int unsigned MAX_QUOTIENT = 4095,
  parameter int unsigned DIVISOR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_wdata
);

  localparam int unsigned QC_W  = $clog2(MAX_QUOTIENT + 1);
  localparam int unsigned EDIV_W = (DIVISOR_BITS < DIV_W) ? DIVISOR_BITS : DIV_W;
  localparam logic [QC_W-1:0] QC_MAX = QC_W'(MAX_QUOTIENT);

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_UNARY  = 4'b0010,
    PH_PREFIX = 4'b0100,
    PH_EXTRA  = 4'b1000
  } phase_t;

  // Remainder width b = ceil(log2 m), found from the top set bit of m - 1.
  function automatic logic [RW_W-1:0] rem_width(input logic [DIV_W-1:0] m);
    logic [DIV_W-1:0] mm;
    logic [RW_W-1:0]  b;
    mm = m - DIV_W'(1);
    b  = '0;
    for (int i = 0; i < int'(DIV_W); i++) begin
      if (mm[i]) begin
        b = RW_W'(i + 1);
      end
    end
    return b;
  endfunction

  // Configuration and values derived from it
  logic [EDIV_W-1:0] divisor_r, divisor_nxt;
  logic              neg_mode_r, neg_mode_nxt;
  logic [RW_W-1:0]   rem_width_r, rem_width_nxt;
  logic [DIV_W-1:0]  cutoff_r, cutoff_nxt;
  logic [DIV_W-1:0]  m_cur, m_new;

  // Code state
  phase_t              phase_r, phase_nxt;
  logic                sign_r, sign_nxt;
  logic [QC_W-1:0]     qcount_r, qcount_nxt;
  logic [NUM_W-1:0]    qbase_r, qbase_nxt;
  logic [DIV_W-1:0]    rbits_r, rbits_nxt;
  logic [RW_W-1:0]     rcount_r, rcount_nxt;
  logic [LENGTH_W-1:0] bits_r, bits_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic             accept;
  logic             cfg_hit;
  logic             done, overflow, prefix_done;
  logic [NUM_W-1:0] n;
  logic [VALUE_W-1:0] sval;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only a write that lands on a real register restarts the code.
  assign cfg_hit = cfg_we && (cfg_index == CFG_DIVISOR || cfg_index == CFG_NEG_MODE);

  assign m_cur = (divisor_r == '0) ? DIV_W'(1) : DIV_W'(divisor_r);

  // Configuration path
  always_comb begin
    divisor_nxt  = divisor_r;
    neg_mode_nxt = neg_mode_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DIVISOR:  divisor_nxt  = cfg_wdata[EDIV_W-1:0];
        CFG_NEG_MODE: neg_mode_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
    m_new         = (divisor_nxt == '0) ? DIV_W'(1) : DIV_W'(divisor_nxt);
    rem_width_nxt = rem_width(m_new);
    cutoff_nxt    = DIV_W'((17'd1 << rem_width_nxt) - {1'b0, m_new});
  end

  // Decode step for one accepted bit
  always_comb begin
    logic [DIV_W:0] combined;
    phase_nxt   = phase_r;
    sign_nxt    = sign_r;
    qcount_nxt  = qcount_r;
    qbase_nxt   = qbase_r;
    rbits_nxt   = rbits_r;
    rcount_nxt  = rcount_r;
    bits_nxt    = bits_r + LENGTH_W'(1);
    done        = 1'b0;
    overflow    = 1'b0;
    prefix_done = 1'b0;
    n           = '0;
    combined    = {rbits_r, in_data.coded_bit};

    if (phase_r == PH_START && neg_mode_r) begin
      sign_nxt  = in_data.coded_bit;
      phase_nxt = PH_UNARY;
    end else if (phase_r == PH_START || phase_r == PH_UNARY) begin
      phase_nxt = PH_UNARY;
      if (!in_data.coded_bit) begin
        if (qcount_r >= QC_MAX) begin
          overflow = 1'b1;
        end else begin
          qcount_nxt = qcount_r + QC_W'(1);
          qbase_nxt  = qbase_r + NUM_W'(m_cur);
        end
      end else if (rem_width_r == '0) begin
        n    = qbase_r;
        done = 1'b1;
      end else begin
        rbits_nxt  = '0;
        rcount_nxt = '0;
        if (rem_width_r == RW_W'(1)) begin
          prefix_done = 1'b1;
        end else begin
          phase_nxt = PH_PREFIX;
        end
      end
    end else if (phase_r == PH_PREFIX) begin
      rbits_nxt  = combined[DIV_W-1:0];
      rcount_nxt = rcount_r + RW_W'(1);
      if (rcount_nxt >= rem_width_r - RW_W'(1)) begin
        prefix_done = 1'b1;
      end
    end else begin
      n    = qbase_r + NUM_W'(combined) - NUM_W'(cutoff_r);
      done = 1'b1;
    end

    // Short remainders end here; long ones need one more bit.
    if (prefix_done) begin
      if (rbits_nxt < cutoff_r) begin
        n    = qbase_r + NUM_W'(rbits_nxt);
        done = 1'b1;
      end else begin
        phase_nxt = PH_EXTRA;
      end
    end
  end

  // Signed mapping of the unsigned code value
  always_comb begin
    if (neg_mode_r) begin
      sval = sign_r ? (VALUE_W'(0) - n[VALUE_W-1:0]) : n[VALUE_W-1:0];
    end else if (!n[0]) begin
      sval = n[NUM_W-1:1];
    end else begin
      sval = ~n[NUM_W-1:1];
    end
  end

  // Result word and end of code
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (accept && (done || overflow || in_data.stream_end)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.code_length = bits_nxt;
      if (overflow) begin
        out_data_nxt.status        = ST_OVERFLOW;
        out_data_nxt.decoded_value = '0;
      end else if (done) begin
        out_data_nxt.status        = ST_OK;
        out_data_nxt.decoded_value = sval;
      end else begin
        out_data_nxt.status        = ST_TRUNC;
        out_data_nxt.decoded_value = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r   <= EDIV_W'(DIVISOR_RESET);
      neg_mode_r  <= 1'b0;
      rem_width_r <= RW_W'(2);
      cutoff_r    <= '0;
      phase_r     <= PH_START;
      sign_r      <= 1'b0;
      qcount_r    <= '0;
      qbase_r     <= '0;
      rbits_r     <= '0;
      rcount_r    <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        divisor_r   <= divisor_nxt;
        neg_mode_r  <= neg_mode_nxt;
        rem_width_r <= rem_width_nxt;
        cutoff_r    <= cutoff_nxt;
      end
      if (cfg_hit || (accept && (done || overflow || in_data.stream_end))) begin
        // A finished code or a register write starts a fresh code.
        phase_r  <= PH_START;
        sign_r   <= 1'b0;
        qcount_r <= '0;
        qbase_r  <= '0;
        rbits_r  <= '0;
        rcount_r <= '0;
        bits_r   <= '0;
      end else if (accept) begin
        phase_r  <= phase_nxt;
        sign_r   <= sign_nxt;
        qcount_r <= qcount_nxt;
        qbase_r  <= qbase_nxt;
        rbits_r  <= rbits_nxt;
        rcount_r <= rcount_nxt;
        bits_r   <= bits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // A failed code never carries a value.
  a_fail_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.decoded_value == '0)
    else $error("non-ok result with nonzero value");

  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= QC_MAX)
    else $error("quotient count above bound");

  a_cfg_clears_code: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> phase_r == PH_START && bits_r == '0)
    else $error("register write left a code in progress");

  a_start_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_START |-> bits_r == '0 && qcount_r == '0)
    else $error("start phase with bits already consumed");

  a_prefix_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PREFIX |-> rcount_r + RW_W'(1) < rem_width_r)
    else $error("remainder prefix count past its width");

endmodule
